// ----- hw/rtl/max_average_pooling_assert.svh -----
// Assertion macros for the pooling block checker
`ifndef MAX_AVERAGE_POOLING_ASSERT_SVH
`define MAX_AVERAGE_POOLING_ASSERT_SVH

// Implication to the next cycle, ignored while in reset
`define MAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication to the next cycle, checked through reset too
`define MAP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/map_pkg.sv -----
// Types and constants shared by the pooling block modules
package map_pkg;
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int MAX_POOL = 16;

  localparam int SampleW = 16;
  localparam int SumW    = 24;
  localparam int RowW    = 12;
  localparam int ColW    = 10;
  localparam int RowsW   = 13;
  localparam int ColsW   = 11;
  localparam int PoolW   = 5;
  localparam int PsqW    = 9;
  localparam int CfgW    = 13;
  localparam int IdxW    = 3;

  localparam logic [IdxW-1:0] REG_ROWS = 3'd0;
  localparam logic [IdxW-1:0] REG_COLS = 3'd1;
  localparam logic [IdxW-1:0] REG_POOL = 3'd2;
  localparam logic [IdxW-1:0] REG_MODE = 3'd3;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [RowW-1:0]           wr;
    logic [ColW-1:0]           wc;
    logic                      first;
    logic                      last;
    logic                      fend;
  } item_t;

  typedef struct packed {
    logic            mode;
    logic [PsqW-1:0] psq;
  } cfg_t;
endpackage

// ----- hw/rtl/max_average_pooling.sv -----
// Top level of the streaming 2-D max / average pooling block
// Samples enter as signed Q8.8 words in row-major order on sample/in_valid;
// the block raises in_stall while its four-word queue is full.
// Results leave on pooled/out_row/out_col/frame_end with out_valid and
// are held unchanged while out_stall is high.
// A result appears on the last sample of each whole window; samples in
// edge leftovers produce nothing and are accepted but not queued.
// The front takes one sample per cycle while the queue has room.
// The back takes a new sample only when idle: it reads the line store,
// then updates it; a sample that closes a window also loads the result
// (in average mode through the bit-serial divider) and holds it while
// out_stall is high. The back sets throughput.
// Configuration is written by cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Any write to rows, cols, pool size or mode restarts the frame
// position.
// Reset restores rows 1, cols 1, pool size 2, max mode and clears the
// queue and position; the line store needs no clearing.
module max_average_pooling (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [map_pkg::IdxW-1:0]           cfg_index,
  input  logic [map_pkg::CfgW-1:0]           cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [map_pkg::SampleW-1:0] sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [map_pkg::SampleW-1:0] pooled,
  output logic [map_pkg::RowW-1:0]           out_row,
  output logic [map_pkg::ColW-1:0]           out_col,
  output logic                               frame_end
);
  import map_pkg::*;

  logic  push, pop, empty, full;
  item_t push_item, pop_item;
  cfg_t  cfg;

  assign in_stall = full;

  map_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall, .sample,
    .push, .push_item, .cfg
  );

  map_fifo u_fifo (
    .clk, .rst, .push, .push_item, .pop, .pop_item, .empty, .full
  );

  map_back u_back (
    .clk, .rst, .cfg, .empty, .pop_item, .pop, .out_valid, .out_stall,
    .pooled, .out_row, .out_col, .frame_end
  );
endmodule

// ----- hw/rtl/map_front.sv -----
// Front end: config registers, raster position tracking, window classification
module map_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [map_pkg::IdxW-1:0]      cfg_index,
  input  logic [map_pkg::CfgW-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [map_pkg::SampleW-1:0] sample,
  output logic                          push,
  output map_pkg::item_t                push_item,
  output map_pkg::cfg_t                 cfg
);
  import map_pkg::*;

  logic [RowsW-1:0] rows;
  logic [ColsW-1:0] cols;
  logic [PoolW-1:0] p;
  logic             mode;
  logic [PsqW-1:0]  psq;

  logic [RowW-1:0]  r, row_base, wr;
  logic [ColW-1:0]  c, col_base, wc;
  logic [PoolW-1:0] rin, cin;

  logic [RowsW-1:0] rows_w;
  logic [ColsW-1:0] cols_w;
  logic [PoolW-1:0] pool_w;
  logic             win_ok, fend, acc;

  always_comb begin
    if (cfg_data == '0) begin
      rows_w = RowsW'(1);
    end else if (32'(cfg_data) > MAX_ROWS) begin
      rows_w = RowsW'(MAX_ROWS);
    end else begin
      rows_w = cfg_data;
    end
    if (cfg_data[ColsW-1:0] == '0) begin
      cols_w = ColsW'(1);
    end else if (32'(cfg_data[ColsW-1:0]) > MAX_COLS) begin
      cols_w = ColsW'(MAX_COLS);
    end else begin
      cols_w = cfg_data[ColsW-1:0];
    end
    if (cfg_data[PoolW-1:0] == '0) begin
      pool_w = PoolW'(1);
    end else if (32'(cfg_data[PoolW-1:0]) > MAX_POOL) begin
      pool_w = PoolW'(MAX_POOL);
    end else begin
      pool_w = cfg_data[PoolW-1:0];
    end
  end

  assign acc    = in_valid && !in_stall;
  assign win_ok = (14'(row_base) + 14'(p) <= 14'(rows)) &&
                  (12'(col_base) + 12'(p) <= 12'(cols));
  assign fend   = (14'(row_base) + 14'({p, 1'b0}) > 14'(rows)) &&
                  (12'(col_base) + 12'({p, 1'b0}) > 12'(cols));

  assign push             = acc && win_ok;
  assign push_item.sample = sample;
  assign push_item.wr     = wr;
  assign push_item.wc     = wc;
  assign push_item.first  = (rin == '0) && (cin == '0);
  assign push_item.last   = (rin == p - 1'b1) && (cin == p - 1'b1);
  assign push_item.fend   = fend;
  assign cfg.mode         = mode;
  assign cfg.psq          = psq;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= RowsW'(1);
      cols <= ColsW'(1);
      p    <= PoolW'(2);
      psq  <= PsqW'(4);
      mode <= MODE_MAX;
      r <= '0; row_base <= '0; wr <= '0; rin <= '0;
      c <= '0; col_base <= '0; wc <= '0; cin <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows <= rows_w;
        REG_COLS: cols <= cols_w;
        REG_POOL: begin
          p   <= pool_w;
          psq <= PsqW'(pool_w * pool_w);
        end
        REG_MODE: mode <= cfg_data[0];
        default: ;
      endcase
      if (cfg_index == REG_ROWS || cfg_index == REG_COLS ||
          cfg_index == REG_POOL || cfg_index == REG_MODE) begin
        r <= '0; row_base <= '0; wr <= '0; rin <= '0;
        c <= '0; col_base <= '0; wc <= '0; cin <= '0;
      end
    end else if (acc) begin
      if (ColsW'(c) + 1'b1 == cols) begin
        c <= '0; col_base <= '0; wc <= '0; cin <= '0;
        if (RowsW'(r) + 1'b1 == rows) begin
          r <= '0; row_base <= '0; wr <= '0; rin <= '0;
        end else begin
          r <= r + 1'b1;
          if (rin == p - 1'b1) begin
            rin      <= '0;
            wr       <= wr + 1'b1;
            row_base <= row_base + RowW'(p);
          end else begin
            rin <= rin + 1'b1;
          end
        end
      end else begin
        c <= c + 1'b1;
        if (cin == p - 1'b1) begin
          cin      <= '0;
          wc       <= wc + 1'b1;
          col_base <= col_base + ColW'(p);
        end else begin
          cin <= cin + 1'b1;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/map_fifo.sv -----
// Four-entry queue between front and back
module map_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  map_pkg::item_t push_item,
  input  logic           pop,
  output map_pkg::item_t pop_item,
  output logic           empty,
  output logic           full
);
  import map_pkg::*;

  item_t      slots [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign empty    = (count == 3'd0);
  assign full     = (count == 3'd4);
  assign pop_item = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end
endmodule

// ----- hw/rtl/map_back.sv -----
// Back end: line store update, averaging divider and output register
module map_back (
  input  logic                               clk,
  input  logic                               rst,
  input  map_pkg::cfg_t                      cfg,
  input  logic                               empty,
  input  map_pkg::item_t                     pop_item,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [map_pkg::SampleW-1:0] pooled,
  output logic [map_pkg::RowW-1:0]           out_row,
  output logic [map_pkg::ColW-1:0]           out_col,
  output logic                               frame_end
);
  import map_pkg::*;

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic signed [SampleW-1:0] mem_max [MAX_COLS];
  logic signed [SumW-1:0]    mem_sum [MAX_COLS];
  logic signed [SampleW-1:0] rd_max;
  logic signed [SumW-1:0]    rd_sum;

  logic [1:0]             state;
  item_t                  cur;
  logic signed [SampleW-1:0] new_max;
  logic signed [SumW-1:0]    new_sum;
  logic [SumW-1:0]        q, q_next;
  logic [PsqW-1:0]        rem, rem_next;
  logic [PsqW:0]          rem_sh;
  logic                   neg;
  logic [4:0]             cnt;
  logic signed [SumW:0]   quot;
  logic signed [SampleW-1:0] avg;

  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    new_max = (cur.first || cur.sample > rd_max) ? cur.sample : rd_max;
    new_sum = cur.first ? SumW'(cur.sample) : rd_sum + SumW'(cur.sample);
    rem_sh  = {rem, q[SumW-1]};
    if (rem_sh >= {1'b0, cfg.psq}) begin
      rem_next = PsqW'(rem_sh - {1'b0, cfg.psq});
      q_next   = {q[SumW-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[PsqW-1:0];
      q_next   = {q[SumW-2:0], 1'b0};
    end
    quot = neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
    if (quot > 25'sd32767) begin
      avg = 16'sh7fff;
    end else if (quot < -25'sd32768) begin
      avg = -16'sh8000;
    end else begin
      avg = quot[SampleW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_max <= mem_max[AW'(pop_item.wc)];
      rd_sum <= mem_sum[AW'(pop_item.wc)];
    end
    if (state == S_UPD) begin
      mem_max[AW'(cur.wc)] <= new_max;
      mem_sum[AW'(cur.wc)] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= pop_item;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          out_row   <= cur.wr;
          out_col   <= cur.wc;
          frame_end <= cur.fend;
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (cfg.mode == MODE_AVG) begin
            neg   <= new_sum[SumW-1];
            q     <= new_sum[SumW-1] ? -new_sum : new_sum;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            pooled    <= new_max;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_DIV: begin
          q   <= q_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == 5'(SumW - 1)) begin
            pooled    <= avg;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/map_checker.sv -----
// Port-level assertion checker for the pooling block, with its bind
`include "max_average_pooling_assert.svh"

module map_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] pooled,
  input logic [11:0] out_row,
  input logic [9:0]  out_col,
  input logic        frame_end
);
  logic [38:0] payload;

  assign payload = {pooled, out_row, out_col, frame_end};

  `MAP_ASSERT_ALWAYS(a_rst_idle, rst, !out_valid, "output valid after reset")
  `MAP_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "valid dropped")
  `MAP_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(payload), "payload moved")
  `MAP_ASSERT_NEXT(a_gap, out_valid && !out_stall, !out_valid, "results back to back")
endmodule

bind max_average_pooling map_checker u_map_checker (
  .clk, .rst, .out_valid, .out_stall, .pooled, .out_row, .out_col, .frame_end
);

// ----- sim/tb_max_average_pooling.sv -----
// Self-checking testbench for the streaming max / average pooling block
module tb_max_average_pooling;
  import map_pkg::*;

  localparam int LIMIT = 2000000;
  localparam logic [IdxW-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SampleW-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SampleW-1:0] pooled;
  logic [RowW-1:0] out_row;
  logic [ColW-1:0] out_col;
  logic frame_end;

  typedef struct packed {
    logic signed [SampleW-1:0] pooled;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic fend;
  } pool_res_t;

  max_average_pooling uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int n_rows, n_cols, psize;
  logic avg_mode;
  int rpos, cpos;
  int wmax [1024];
  int wsum [1024];

  logic signed [SampleW-1:0] pending_q[$];
  pool_res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_off = 0;
  int in_gap = 0, out_gap = 0;

  function automatic int clamp_reg(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic pool_predict(logic signed [SampleW-1:0] s);
    int wr, wc, rin, cin, v;
    pool_res_t res;
    wr = rpos / psize; wc = cpos / psize;
    rin = rpos % psize; cin = cpos % psize;
    if (wr < n_rows / psize && wc < n_cols / psize) begin
      if (rin == 0 && cin == 0) begin
        wmax[wc] = int'(s); wsum[wc] = int'(s);
      end else begin
        if (int'(s) > wmax[wc]) wmax[wc] = int'(s);
        wsum[wc] += int'(s);
      end
      if (rin == psize - 1 && cin == psize - 1) begin
        v = avg_mode ? wsum[wc] / (psize * psize) : wmax[wc];
        res.pooled = v[15:0];
        res.row = wr[RowW-1:0];
        res.col = wc[ColW-1:0];
        res.fend = (wr == n_rows / psize - 1) && (wc == n_cols / psize - 1);
        expected_q.insert(expected_q.size(), res);
      end
    end
    cpos++;
    if (cpos >= n_cols) begin
      cpos = 0; rpos++;
      if (rpos >= n_rows) rpos = 0;
    end
  endtask

  task automatic reg_write(logic [IdxW-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[CfgW-1:0];
    case (idx)
      REG_ROWS: n_rows = clamp_reg(val & 16'h1FFF, 4096);
      REG_COLS: n_cols = clamp_reg(val & 16'h7FF, 1024);
      REG_POOL: psize = clamp_reg(val & 16'h1F, 16);
      REG_MODE: avg_mode = val[0];
      default: ;
    endcase
    if (idx <= REG_MODE) begin
      rpos = 0; cpos = 0;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic run_phase(int r, int c, int p, int m, int nframes, int kind);
    logic signed [SampleW-1:0] s;
    reg_write(REG_ROWS, r);
    reg_write(REG_COLS, c);
    reg_write(REG_POOL, p);
    reg_write(REG_MODE, m);
    for (int f = 0; f < nframes; f++) begin
      for (int i = 0; i < n_rows * n_cols; i++) begin
        case (kind)
          0: s = SampleW'($urandom);
          1: s = 16'sh7FFF;
          2: s = -16'sh8000;
          default: s = ($urandom_range(0, 1)) ? 16'sh7FFF : -16'sh8000;
        endcase
        pending_q.insert(pending_q.size(), s);
        pool_predict(s);
      end
    end
    drain();
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(pending_q.pop_front());
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          sample <= pending_q[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_off <= 300;
      hold_used <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected word: %0d row %0d col %0d", pooled, out_row, out_col);
      end else begin
        if (expected_q[0] != {pooled, out_row, out_col, frame_end}) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp %0d r%0d c%0d e%0b got %0d r%0d c%0d e%0b",
                     expected_q[0].pooled, expected_q[0].row, expected_q[0].col,
                     expected_q[0].fend, pooled, out_row, out_col, frame_end);
        end
        void'(expected_q.pop_front());
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if (cycles > LIMIT) begin
      $display("max_average_pooling verification failed");
      $finish;
    end
  end

  initial begin
    n_rows = 1; n_cols = 1; psize = 2; avg_mode = MODE_MAX; rpos = 0; cpos = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed
    run_phase(4, 4, 2, MODE_MAX, 1, 3);
    run_phase(4, 4, 2, MODE_AVG, 1, 1);
    run_phase(2, 2, 2, MODE_AVG, 1, 2);
    run_phase(3, 5, 0, MODE_MAX, 1, 0);
    run_phase(5, 5, 2, MODE_AVG, 1, 0);
    run_phase(1, 3, 2, MODE_MAX, 1, 0);
    reg_write(REG_NONE, 5);
    run_phase(1, 16'h1FFF, 31, MODE_AVG, 0, 0);
    run_phase(0, 2000, 1, MODE_MAX, 0, 0);
    run_phase(1, 0, 1, MODE_MAX, 1, 0);
    // pressure: long receiver hold-off while input keeps flowing
    hold_go = 1'b1;
    run_phase(8, 8, 1, MODE_AVG, 2, 0);
    // random
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 13) calm = 1'b1;
      run_phase($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 4),
                $urandom_range(0, 1), 1, $urandom_range(0, 4) == 0 ? 3 : 0);
    end
    run_phase(16, 16, 16, MODE_AVG, 1, 3);
    run_phase(16, 16, 16, MODE_MAX, 1, 0);
    run_phase(1, 1024, 1, MODE_MAX, 1, 0);
    if (errors == 0) begin
      $display("max_average_pooling verification clean");
    end else begin
      $display("max_average_pooling verification failed");
    end
    $finish;
  end
endmodule
